FILE: src/msfc_pkg.sv
package msfc_pkg;

    // Fixed field widths of the request and result channels.
    localparam int VERT_BITS      = 6;
    localparam int WEIGHT_IN_BITS = 16;
    localparam int COUNT_BITS     = 7;
    localparam int TREE_BITS      = 22;
    localparam int DROP_BITS      = 16;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 1024;
    localparam int DEF_WEIGHT_BITS  = 16;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // One classified edge request handed from the front to the back.
    typedef struct packed {
        logic                      store;
        logic                      last;
        logic [VERT_BITS-1:0]      src;
        logic [VERT_BITS-1:0]      dst;
        logic [WEIGHT_IN_BITS-1:0] weight;
        logic [DROP_BITS-1:0]      dropped;
    } edge_cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_START,
        S_UP_CMP,
        S_UP_PUT,
        S_KR_CHK,
        S_POP,
        S_DN,
        S_CHK_V,
        S_FD_WALK,
        S_FD_COMP,
        S_JOIN_A,
        S_JOIN_B,
        S_CNT_CHK,
        S_EM_CHK
    } back_state_t;

endpackage

FILE: src/msfc_ifs.sv
interface msfc_edge_if
    import msfc_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [VERT_BITS-1:0]      src_vertex;
    logic [VERT_BITS-1:0]      dest_vertex;
    logic [WEIGHT_IN_BITS-1:0] edge_weight;
    logic                      last_edge;

    modport source (output valid, src_vertex, dest_vertex, edge_weight, last_edge,
                    input ready);
    modport sink (input valid, src_vertex, dest_vertex, edge_weight, last_edge,
                  output ready);
endinterface

interface msfc_result_if
    import msfc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] component_total;
    logic [VERT_BITS-1:0]  root_vertex;
    logic [COUNT_BITS-1:0] vertex_count;
    logic [TREE_BITS-1:0]  tree_weight;
    logic [DROP_BITS-1:0]  dropped_edges;
    logic                  last_component;

    modport source (output valid, component_total, root_vertex, vertex_count,
                    tree_weight, dropped_edges, last_component, input ready);
    modport sink (input valid, component_total, root_vertex, vertex_count,
                  tree_weight, dropped_edges, last_component, output ready);
endinterface

interface msfc_cfg_if
    import msfc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] num_vertices;

    modport source (output valid, num_vertices, input ready);
    modport sink (input valid, num_vertices, output ready);
endinterface

FILE: src/min_spanning_forest_components_unit.sv
// Channel      Direction  Payload
// edge_in      in         src_vertex, dest_vertex, edge_weight, last_edge
// result_out   out        component_total, root_vertex, vertex_count, tree_weight,
//                         dropped_edges, last_component
// cfg          in         num_vertices (write data only, always ready)
//
// An edge request sifts up through the heap in the back end, one heap level per cycle,
// set by the single write port of the heap memory.
// The last edge then runs, for each popped edge, the pop and sift-down, a root search
// with path compression for each of the two endpoints, and the join,
// followed by two sweeps over the vertex records to count and emit.
// Reset is asynchronous and active low; it clears control state and all vertex
// records at once, so no clearing pass is needed.
// The front keeps accepting edges into a four-entry queue while the back works, and
// a full result register stalls only the emission sweep.
module min_spanning_forest_components_unit
    import msfc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES,
    parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    msfc_edge_if.sink     edge_in,
    msfc_result_if.source result_out,
    msfc_cfg_if.sink      cfg
);

    localparam int VCW = $clog2(MAX_VERTICES + 1);

    // Classified edge requests waiting for the back end.
    edge_cmd_t      push_data;
    edge_cmd_t      pop_data;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;

    // Vertex count in force, already clamped to the legal range.
    logic [VCW-1:0] veff;

    // The front checks endpoints and capacity, counts dropped edges and holds
    // the vertex count register.
    msfc_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .edge_in (edge_in),
        .cfg     (cfg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (push_data),
        .veff    (veff)
    );

    msfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // The back end owns the heap and the union-find records, runs the joins
    // and sweeps the roots out in ascending order.
    msfc_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (pop_data),
        .q_pop      (q_pop),
        .veff       (veff),
        .result_out (result_out)
    );

endmodule

FILE: src/msfc_front.sv
module msfc_front
    import msfc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES,
    localparam int VCW         = $clog2(MAX_VERTICES + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    msfc_edge_if.sink       edge_in,
    msfc_cfg_if.sink        cfg,
    input  logic            q_full,
    output logic            q_push,
    output edge_cmd_t       q_data,
    output logic [VCW-1:0]  veff
);

    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int EXW = VERT_BITS + 1;

    logic [COUNT_BITS-1:0] nv_reg;
    logic [CW-1:0]         stored_reg, stored_next;
    logic [DROP_BITS-1:0]  rej_reg, rej_next;
    logic                  accept;
    logic                  bad;

    assign cfg.ready     = 1'b1;
    assign edge_in.ready = !q_full;
    assign accept        = edge_in.valid && edge_in.ready;

    // Vertex count in force: zero acts as one, anything above capacity as capacity.
    always_comb
    begin
        if (nv_reg == '0)
            veff = VCW'(1);
        else if (32'(nv_reg) > MAX_VERTICES)
            veff = VCW'(MAX_VERTICES);
        else
            veff = VCW'(nv_reg);
    end

    assign bad = (EXW'(edge_in.src_vertex) >= EXW'(veff))
              || (EXW'(edge_in.dest_vertex) >= EXW'(veff))
              || (stored_reg == CW'(MAX_EDGES));

    always_comb
    begin
        stored_next = stored_reg;
        rej_next    = rej_reg;
        if (accept)
        begin
            if (bad && (rej_reg != '1))
                rej_next = rej_reg + DROP_BITS'(1);
            if (!bad)
                stored_next = stored_reg + CW'(1);
            if (edge_in.last_edge)
            begin
                stored_next = '0;
                rej_next    = '0;
            end
        end
    end

    assign q_push         = accept && (!bad || edge_in.last_edge);
    assign q_data.store   = !bad;
    assign q_data.last    = edge_in.last_edge;
    assign q_data.src     = edge_in.src_vertex;
    assign q_data.dst     = edge_in.dest_vertex;
    assign q_data.weight  = edge_in.edge_weight;
    assign q_data.dropped = (bad && (rej_reg != '1)) ? rej_reg + DROP_BITS'(1) : rej_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg     <= COUNT_BITS'(64);
            stored_reg <= '0;
            rej_reg    <= '0;
        end
        else
        begin
            if (cfg.valid)
                nv_reg <= cfg.num_vertices;
            stored_reg <= stored_next;
            rej_reg    <= rej_next;
        end
    end

endmodule

FILE: src/msfc_queue.sv
module msfc_queue
    import msfc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  edge_cmd_t push_data,
    output logic      full,
    input  logic      pop,
    output edge_cmd_t pop_data,
    output logic      empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    edge_cmd_t         slots [DEPTH];
    logic [PW-1:0]     wr_reg, rd_reg;
    logic [NW-1:0]     fill_reg;
    logic              do_push, do_pop;

    assign full     = (fill_reg == NW'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slots[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (32'(wr_reg) == DEPTH - 1) ? '0 : wr_reg + PW'(1);
            if (do_pop)
                rd_reg <= (32'(rd_reg) == DEPTH - 1) ? '0 : rd_reg + PW'(1);
            if (do_push && !do_pop)
                fill_reg <= fill_reg + NW'(1);
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - NW'(1);
        end
    end

endmodule

FILE: src/msfc_back.sv
module msfc_back
    import msfc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES,
    parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS,
    localparam int VCW         = $clog2(MAX_VERTICES + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  edge_cmd_t      q_data,
    output logic           q_pop,
    input  logic [VCW-1:0] veff,
    msfc_result_if.source  result_out
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int AW  = $clog2(MAX_EDGES);
    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int IXW = AW + 2;
    localparam int RKW = $clog2(VW + 1);
    localparam int HEW = 2 * VERT_BITS + WEIGHT_BITS;
    localparam int EXW = VERT_BITS + 1;

    typedef struct packed {
        logic [VW-1:0]         parent;
        logic [RKW-1:0]        rank;
        logic [TREE_BITS-1:0]  weight;
        logic [COUNT_BITS-1:0] size;
    } vrec_t;

    // Heap store: entry is {src, dst, weight}.
    logic [HEW-1:0] hmem [MAX_EDGES];
    logic [HEW-1:0] hrd_a, hrd_b, hwd;
    logic [AW-1:0]  ha, hb, hwa;
    logic           hwe;

    // Vertex record store with a valid bit per entry.
    vrec_t                  vmem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] vvalid_reg;
    vrec_t                  vrd, vwd, vrec;
    logic [VW-1:0]          vaddr, vaddr_q, vwa;
    logic                   vvalid_q, vwe, vclear;

    back_state_t           state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [AW-1:0]         idx_reg, idx_next, par_reg, par_next;
    logic [HEW-1:0]        new_reg, new_next, pop_reg, pop_next;
    logic                  last_reg, last_next, which_reg, which_next;
    logic [DROP_BITS-1:0]  drop_reg, drop_next;
    logic [VCW-1:0]        joins_reg, joins_next, vi_reg, vi_next;
    logic [VCW-1:0]        comps_reg, comps_next, n_reg, n_next;
    logic [VW-1:0]         vc_reg, vc_next, start_reg, start_next;
    logic [VW-1:0]         rx_reg, rx_next, ry_reg, ry_next;
    vrec_t                 recx_reg, recx_next, recy_reg, recy_next;

    logic                  out_valid_reg, out_free, out_load;
    logic [COUNT_BITS-1:0] out_total_reg;
    logic [VERT_BITS-1:0]  out_root_reg;
    logic [COUNT_BITS-1:0] out_size_reg;
    logic [TREE_BITS-1:0]  out_weight_reg;
    logic [DROP_BITS-1:0]  out_drop_reg;
    logic                  out_last_reg;

    logic [WEIGHT_BITS-1:0] x_w, a_w, b_w, mw;
    logic [IXW-1:0]         l_idx, r_idx, m_idx, cnt_x;
    logic                   take_l, take_r, kr_go, pop_bad, v_root, vi_last;
    logic                   keep_y, rank_eq;
    logic [VERT_BITS-1:0]   pop_src, pop_dst;
    vrec_t                  rec_keep, rec_gone;
    logic [VW-1:0]          keep_v, gone_v;

    assign x_w = new_reg[WEIGHT_BITS-1:0];
    assign a_w = hrd_a[WEIGHT_BITS-1:0];
    assign b_w = hrd_b[WEIGHT_BITS-1:0];

    assign l_idx  = {1'b0, idx_reg, 1'b1};
    assign r_idx  = l_idx + IXW'(1);
    assign cnt_x  = IXW'(cnt_reg);
    assign take_l = (l_idx < cnt_x) && (a_w < x_w);
    assign mw     = take_l ? a_w : x_w;
    assign take_r = (r_idx < cnt_x) && (b_w < mw);
    assign m_idx  = take_r ? r_idx : l_idx;

    assign kr_go   = (EXW'(joins_reg) + EXW'(1) < EXW'(veff)) && (cnt_reg != '0);
    assign pop_src = pop_reg[HEW-1 -: VERT_BITS];
    assign pop_dst = pop_reg[WEIGHT_BITS +: VERT_BITS];
    assign pop_bad = (EXW'(pop_src) >= EXW'(veff)) || (EXW'(pop_dst) >= EXW'(veff));

    // A vertex never written reads as a singleton root of its own.
    always_comb
    begin
        if (vvalid_q)
            vrec = vrd;
        else
        begin
            vrec.parent = vaddr_q;
            vrec.rank   = '0;
            vrec.weight = '0;
            vrec.size   = COUNT_BITS'(1);
        end
    end

    assign v_root  = (vrec.parent == vaddr_q);
    assign vi_last = (EXW'(vi_reg) + EXW'(1) == EXW'(veff));

    assign keep_y   = (recx_reg.rank < recy_reg.rank);
    assign rank_eq  = (recx_reg.rank == recy_reg.rank);
    assign keep_v   = keep_y ? ry_reg : rx_reg;
    assign gone_v   = keep_y ? rx_reg : ry_reg;
    assign rec_keep = keep_y ? recy_reg : recx_reg;
    assign rec_gone = keep_y ? recx_reg : recy_reg;

    assign out_free = !out_valid_reg || result_out.ready;
    assign out_load = (state_reg == S_EM_CHK) && v_root && out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (!q_empty)
                begin
                    if (q_data.store)
                        state_next = S_UP_START;
                    else if (q_data.last)
                        state_next = S_KR_CHK;
                end
            S_UP_START:
                if (idx_reg == '0)
                    state_next = last_reg ? S_KR_CHK : S_IDLE;
                else
                    state_next = S_UP_CMP;
            S_UP_CMP:
                if (x_w < a_w)
                begin
                    if (par_reg == '0)
                        state_next = S_UP_PUT;
                end
                else
                    state_next = last_reg ? S_KR_CHK : S_IDLE;
            S_UP_PUT:
                state_next = last_reg ? S_KR_CHK : S_IDLE;
            S_KR_CHK:
                state_next = kr_go ? S_POP : S_CNT_CHK;
            S_POP:
                state_next = (cnt_reg == CW'(1)) ? S_CHK_V : S_DN;
            S_DN:
                if (!(take_l || take_r))
                    state_next = S_CHK_V;
            S_CHK_V:
                state_next = pop_bad ? S_KR_CHK : S_FD_WALK;
            S_FD_WALK:
                if (v_root)
                    state_next = S_FD_COMP;
            S_FD_COMP:
                if (v_root)
                    state_next = which_reg ? S_JOIN_A : S_FD_WALK;
            S_JOIN_A:
                state_next = (rx_reg == ry_reg) ? S_KR_CHK : S_JOIN_B;
            S_JOIN_B:
                state_next = S_KR_CHK;
            S_CNT_CHK:
                if (vi_last)
                    state_next = S_EM_CHK;
            S_EM_CHK:
                if ((!v_root || out_free) && vi_last)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        par_next   = par_reg;
        new_next   = new_reg;
        pop_next   = pop_reg;
        last_next  = last_reg;
        which_next = which_reg;
        drop_next  = drop_reg;
        joins_next = joins_reg;
        vi_next    = vi_reg;
        comps_next = comps_reg;
        n_next     = n_reg;
        vc_next    = vc_reg;
        start_next = start_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        recx_next  = recx_reg;
        recy_next  = recy_reg;
        q_pop      = 1'b0;
        hwe        = 1'b0;
        hwa        = idx_reg;
        hwd        = new_reg;
        ha         = '0;
        hb         = '0;
        vaddr      = vaddr_q;
        vwe        = 1'b0;
        vwa        = vc_reg;
        vwd        = vrec;
        vclear     = 1'b0;
        case (state_reg)
            S_IDLE:
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    last_next = q_data.last;
                    drop_next = q_data.dropped;
                    new_next  = {q_data.src, q_data.dst, WEIGHT_BITS'(q_data.weight)};
                    if (q_data.store)
                    begin
                        idx_next = AW'(cnt_reg);
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            S_UP_START:
                if (idx_reg == '0)
                    hwe = 1'b1;
                else
                begin
                    ha       = (idx_reg - AW'(1)) >> 1;
                    par_next = (idx_reg - AW'(1)) >> 1;
                end
            S_UP_CMP:
                begin
                    hwe = 1'b1;
                    if (x_w < a_w)
                    begin
                        hwd      = hrd_a;
                        idx_next = par_reg;
                        ha       = (par_reg - AW'(1)) >> 1;
                        par_next = (par_reg - AW'(1)) >> 1;
                    end
                end
            S_UP_PUT:
                hwe = 1'b1;
            S_KR_CHK:
                if (kr_go)
                begin
                    ha = '0;
                    hb = AW'(cnt_reg - CW'(1));
                end
                else
                begin
                    vi_next    = '0;
                    comps_next = '0;
                    vaddr      = '0;
                end
            S_POP:
                begin
                    pop_next = hrd_a;
                    new_next = hrd_b;
                    cnt_next = cnt_reg - CW'(1);
                    idx_next = '0;
                    ha       = AW'(1);
                    hb       = AW'(2);
                end
            S_DN:
                begin
                    hwe = 1'b1;
                    if (take_l || take_r)
                    begin
                        hwd      = take_r ? hrd_b : hrd_a;
                        idx_next = AW'(m_idx);
                        ha       = AW'({m_idx, 1'b1});
                        hb       = AW'({m_idx, 1'b1}) + AW'(1);
                    end
                end
            S_CHK_V:
                if (!pop_bad)
                begin
                    which_next = 1'b0;
                    vc_next    = VW'(pop_src);
                    start_next = VW'(pop_src);
                    vaddr      = VW'(pop_src);
                end
            S_FD_WALK:
                if (v_root)
                begin
                    if (which_reg)
                    begin
                        ry_next   = vaddr_q;
                        recy_next = vrec;
                    end
                    else
                    begin
                        rx_next   = vaddr_q;
                        recx_next = vrec;
                    end
                    vc_next = start_reg;
                    vaddr   = start_reg;
                end
                else
                begin
                    vc_next = vrec.parent;
                    vaddr   = vrec.parent;
                end
            S_FD_COMP:
                if (v_root)
                begin
                    if (!which_reg)
                    begin
                        which_next = 1'b1;
                        vc_next    = VW'(pop_dst);
                        start_next = VW'(pop_dst);
                        vaddr      = VW'(pop_dst);
                    end
                end
                else
                begin
                    // Path compression: point this node straight at the root.
                    vwe        = 1'b1;
                    vwa        = vaddr_q;
                    vwd        = vrec;
                    vwd.parent = which_reg ? ry_reg : rx_reg;
                    vc_next    = vrec.parent;
                    vaddr      = vrec.parent;
                end
            S_JOIN_A:
                if (rx_reg != ry_reg)
                begin
                    joins_next = joins_reg + VCW'(1);
                    vwe        = 1'b1;
                    vwa        = gone_v;
                    vwd        = rec_gone;
                    vwd.parent = keep_v;
                end
            S_JOIN_B:
                begin
                    vwe        = 1'b1;
                    vwa        = keep_v;
                    vwd.parent = keep_v;
                    vwd.rank   = rank_eq ? rec_keep.rank + RKW'(1) : rec_keep.rank;
                    vwd.weight = rec_keep.weight + rec_gone.weight
                               + TREE_BITS'(pop_reg[WEIGHT_BITS-1:0]);
                    vwd.size   = rec_keep.size + rec_gone.size;
                end
            S_CNT_CHK:
                begin
                    if (v_root)
                        comps_next = comps_reg + VCW'(1);
                    if (vi_last)
                    begin
                        vi_next = '0;
                        n_next  = '0;
                        vaddr   = '0;
                    end
                    else
                    begin
                        vi_next = vi_reg + VCW'(1);
                        vaddr   = VW'(vi_reg + VCW'(1));
                    end
                end
            S_EM_CHK:
                if (!v_root || out_free)
                begin
                    if (v_root)
                        n_next = n_reg + VCW'(1);
                    if (vi_last)
                    begin
                        // Graph finished: drop every record and empty the heap.
                        vclear     = 1'b1;
                        cnt_next   = '0;
                        joins_next = '0;
                    end
                    else
                    begin
                        vi_next = vi_reg + VCW'(1);
                        vaddr   = VW'(vi_reg + VCW'(1));
                    end
                end
            default:
                begin
                end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hwe)
            hmem[hwa] <= hwd;
        hrd_a <= hmem[ha];
        hrd_b <= hmem[hb];
    end

    always_ff @(posedge clk)
    begin
        if (vwe)
            vmem[vwa] <= vwd;
        vrd     <= vmem[vaddr];
        vaddr_q <= vaddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vvalid_reg <= '0;
            vvalid_q   <= 1'b0;
        end
        else
        begin
            vvalid_q <= vvalid_reg[vaddr];
            if (vclear)
                vvalid_reg <= '0;
            else if (vwe)
                vvalid_reg[vwa] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            joins_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            joins_reg <= joins_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        par_reg   <= par_next;
        new_reg   <= new_next;
        pop_reg   <= pop_next;
        last_reg  <= last_next;
        which_reg <= which_next;
        drop_reg  <= drop_next;
        vi_reg    <= vi_next;
        comps_reg <= comps_next;
        n_reg     <= n_next;
        vc_reg    <= vc_next;
        start_reg <= start_next;
        rx_reg    <= rx_next;
        ry_reg    <= ry_next;
        recx_reg  <= recx_next;
        recy_reg  <= recy_next;
        if (out_load)
        begin
            out_total_reg  <= COUNT_BITS'(comps_reg);
            out_root_reg   <= VERT_BITS'(vaddr_q);
            out_size_reg   <= vrec.size;
            out_weight_reg <= vrec.weight;
            out_drop_reg   <= drop_reg;
            out_last_reg   <= (EXW'(n_reg) + EXW'(1) == EXW'(comps_reg));
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.component_total = out_total_reg;
    assign result_out.root_vertex     = out_root_reg;
    assign result_out.vertex_count    = out_size_reg;
    assign result_out.tree_weight     = out_weight_reg;
    assign result_out.dropped_edges   = out_drop_reg;
    assign result_out.last_component  = out_last_reg;

    // A pop is only started on a non-empty heap.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> (cnt_reg != '0))
        else $error("pop started on an empty heap");

    // The forest never holds more joins than a spanning tree allows.
    a_joins_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_JOIN_B) |-> (EXW'(joins_reg) < EXW'(veff)))
        else $error("join count exceeds vertex count less one");

    // Emission never hands out more components than were counted.
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EM_CHK) |-> (n_reg <= comps_reg))
        else $error("more components emitted than counted");

    // Leaving emission clears the heap for the next graph.
    a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EM_CHK && state_next == S_IDLE) |=> (cnt_reg == '0))
        else $error("heap not cleared after emission");

endmodule
